// ----- sv/tsme_pkg.sv -----
package tsme_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CNT_W     = 2;
  localparam int unsigned PAY_W     = 24;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned COUNT_LSB = 24;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'hff;
  localparam logic [BYTE_W-1:0] STUFF_RST  = 8'hff;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ESCAPE = 2'd0,
    CFG_STUFF  = 2'd1,
    CFG_OEN    = 2'd2
  } cfg_idx_t;

  // commands from the sequencer to the byte shifter
  typedef struct packed {
    logic load;
    logic shift;
  } su_ctl_t;

  // status from the byte shifter back to the sequencer
  typedef struct packed {
    logic [BYTE_W-1:0] byte_val;
    logic              is_esc;
  } su_stat_t;

endpackage

// ----- sv/tsme_in_if.sv -----
interface tsme_in_if import tsme_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] client_tag;
  logic [WORD_W-1:0] message_word;

  modport source(output valid, output client_tag, output message_word, input ready);
  modport sink(input valid, input client_tag, input message_word, output ready);
endinterface

// ----- sv/tsme_out_if.sv -----
interface tsme_out_if import tsme_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_run;

  modport source(output valid, output out_byte, output last_of_run, input ready);
  modport sink(input valid, input out_byte, input last_of_run, output ready);
endinterface

// ----- sv/tsme_shift_unit.sv -----
module tsme_shift_unit import tsme_pkg::*; (
  input  logic              clk,
  input  su_ctl_t           ctl,
  input  logic [PAY_W-1:0]  load_data,
  input  logic [BYTE_W-1:0] escape_value,
  output su_stat_t          stat
);

  logic [PAY_W-1:0] data_r;
  logic [PAY_W-1:0] data_nxt;

  // payload holding register, low byte is the next one out
  always_comb begin
    data_nxt = data_r;
    if (ctl.load) begin
      data_nxt = load_data;
    end else if (ctl.shift) begin
      data_nxt = data_r >> BYTE_W;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // shared compare against the escape value
  assign stat.byte_val = data_r[BYTE_W-1:0];
  assign stat.is_esc   = (data_r[BYTE_W-1:0] == escape_value);

endmodule

// ----- sv/tsme_ctrl.sv -----
module tsme_ctrl import tsme_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // request side
  input  logic              in_valid,
  input  logic [BYTE_W-1:0] in_tag,
  input  logic [CNT_W-1:0]  in_count,
  output logic              in_ready,
  // config
  input  logic [BYTE_W-1:0] stuff_value,
  input  logic              output_enable,
  // byte shifter
  output su_ctl_t           su_ctl,
  input  su_stat_t          su_stat,
  // result side
  output logic              out_valid,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last,
  input  logic              out_ready
);

  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_TAG_STUFF = 5'b00010,
    ST_TAG       = 5'b00100,
    ST_PAYLOAD   = 5'b01000,
    ST_ESC_STUFF = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              have_client_r, have_client_nxt;
  logic [BYTE_W-1:0] last_client_r, last_client_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;

  logic accept;
  logic need_tag;
  logic emit_ok;
  logic emit;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign need_tag = !have_client_r || (last_client_r != in_tag);
  assign emit_ok  = !out_valid_r || out_ready;

  // sequencer: one byte per cycle into the output register, while it is free or being taken
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    have_client_nxt = have_client_r;
    last_client_nxt = last_client_r;
    out_byte_nxt    = out_byte_r;
    out_last_nxt    = out_last_r;
    emit            = 1'b0;
    su_ctl          = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          su_ctl.load     = 1'b1;
          cnt_nxt         = in_count;
          have_client_nxt = 1'b1;
          last_client_nxt = in_tag;
          if (output_enable) begin
            if (need_tag) begin
              state_nxt = ST_TAG_STUFF;
            end else if (in_count != '0) begin
              state_nxt = ST_PAYLOAD;
            end
          end
        end
      end
      ST_TAG_STUFF: begin
        if (emit_ok) begin
          emit         = 1'b1;
          out_byte_nxt = stuff_value;
          out_last_nxt = 1'b0;
          state_nxt    = ST_TAG;
        end
      end
      ST_TAG: begin
        if (emit_ok) begin
          emit         = 1'b1;
          out_byte_nxt = last_client_r;
          out_last_nxt = (cnt_r == '0);
          state_nxt    = (cnt_r == '0) ? ST_IDLE : ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        if (emit_ok) begin
          emit         = 1'b1;
          su_ctl.shift = 1'b1;
          out_byte_nxt = su_stat.byte_val;
          cnt_nxt      = cnt_r - 1'b1;
          if (su_stat.is_esc) begin
            out_last_nxt = 1'b0;
            state_nxt    = ST_ESC_STUFF;
          end else begin
            out_last_nxt = (cnt_r == CNT_W'(1));
            state_nxt    = (cnt_r == CNT_W'(1)) ? ST_IDLE : ST_PAYLOAD;
          end
        end
      end
      ST_ESC_STUFF: begin
        if (emit_ok) begin
          emit         = 1'b1;
          out_byte_nxt = stuff_value;
          out_last_nxt = (cnt_r == '0);
          state_nxt    = (cnt_r == '0) ? ST_IDLE : ST_PAYLOAD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register valid: drops when taken, set on a new byte
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      have_client_r <= 1'b0;
      last_client_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      have_client_r <= have_client_nxt;
      last_client_r <= last_client_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

`ifndef SYNTH
  // tag and escape stuff states are entered only right after a byte was loaded
  a_busy_holds_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TAG || state_r == ST_ESC_STUFF) |-> out_valid_r)
    else $error("tag/stuff state without a pending byte");

  // payload state always has bytes left
  a_payload_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PAYLOAD) |-> (cnt_r != '0))
    else $error("payload state with zero count");

  // client tracking follows every accepted request
  a_client_track: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (have_client_r && last_client_r == $past(in_tag)))
    else $error("last client not updated");

  // disabled output produces no work
  a_oen_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !output_enable) |=> (state_r == ST_IDLE))
    else $error("bytes scheduled while output disabled");
`endif

endmodule

// ----- sv/tagged_stream_mux_escaper_unit.sv -----
// Channel | Dir | Payload                              | Handshake
// in_if   | in  | client_tag[7:0], message_word[31:0]  | valid/ready
// out_if  | out | out_byte[7:0], last_of_run           | valid/ready
// cfg_*   | in  | cfg_idx[1:0], cfg_wdata[7:0]         | cfg_we, no stall
//
// One request is accepted and then emits 0..8 bytes; the next request waits until
// the sequencer is back in idle, so the byte sequencer is the limit.
// A byte waiting in the output register does not block acceptance of the next
// request; a stalled result side holds the sequencer. Reset (rst_n low,
// synchronous) clears the client state and restores register defaults.
module tagged_stream_mux_escaper_unit import tsme_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  tsme_in_if.sink              in_if,
  tsme_out_if.source           out_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [BYTE_W-1:0]    cfg_wdata
);

  logic [BYTE_W-1:0] escape_value_r;
  logic [BYTE_W-1:0] stuff_value_r;
  logic              output_enable_r;

  su_ctl_t  su_ctl;
  su_stat_t su_stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_value_r  <= ESCAPE_RST;
      stuff_value_r   <= STUFF_RST;
      output_enable_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ESCAPE: escape_value_r  <= cfg_wdata;
        CFG_STUFF:  stuff_value_r   <= cfg_wdata;
        CFG_OEN:    output_enable_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // sequencer with client tracking and output register
  tsme_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_if.valid),
    .in_tag        (in_if.client_tag),
    .in_count      (in_if.message_word[COUNT_LSB +: CNT_W]),
    .in_ready      (in_if.ready),
    .stuff_value   (stuff_value_r),
    .output_enable (output_enable_r),
    .su_ctl        (su_ctl),
    .su_stat       (su_stat),
    .out_valid     (out_if.valid),
    .out_byte      (out_if.out_byte),
    .out_last      (out_if.last_of_run),
    .out_ready     (out_if.ready)
  );

  // payload shifter and escape compare
  tsme_shift_unit u_shift (
    .clk          (clk),
    .ctl          (su_ctl),
    .load_data    (in_if.message_word[PAY_W-1:0]),
    .escape_value (escape_value_r),
    .stat         (su_stat)
  );

endmodule
